// ----- hdl/ssp_pkg.sv -----
// ssp_pkg: shared types, constants and microcode rom for the servo slew pulse generator
`timescale 1ns / 1ps

package ssp_pkg;

    // default angle fraction width (1/64 degree)
    localparam int ANGLE_FRAC_BITS_DEF = 6;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 10;
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MIN_ANGLE = 2'd0,
        REG_MAX_ANGLE = 2'd1,
        REG_SPEED     = 2'd2,
        REG_REVERSE   = 2'd3
    } t_reg_idx;

    // stream payload widths
    localparam int S_TDATA_W = 40;  // target_angle 8 + now_ms 32
    localparam int M_TDATA_W = 32;  // angle_now 14 + pulse_us 12 + arrived 1, padded
    localparam int ANGLE_OUT_W = 14;
    localparam int PULSE_W = 12;

    // arithmetic constants
    localparam logic [31:0] K_THOUSAND = 32'd1000;
    localparam logic [31:0] K_HUNDRED = 32'd100;
    localparam logic [11:0] K_PULSE_BASE = 12'd500;
    // floor(2^40 / 1000): quotient estimate is exact or one low
    localparam logic [31:0] RECIP_1000 = 32'd1099511627;
    localparam int RECIP_1000_SH = 40;
    // ceil(2^20 / 9): exact for dividends below 2^17
    localparam logic [31:0] RECIP_9 = 32'd116509;
    localparam int RECIP_9_SH = 20;

    // microcode
    localparam int STEP_W = 4;
    typedef logic [STEP_W-1:0] t_step;

    typedef enum logic [3:0] {
        OP_NOP       = 4'd0,
        OP_LOAD      = 4'd1,
        OP_MUL_SPEED = 4'd2,
        OP_MUL_DIST  = 4'd3,
        OP_CMP       = 4'd4,
        OP_MUL_RECIP = 4'd5,
        OP_MUL_QBACK = 4'd6,
        OP_UPDATE    = 4'd7,
        OP_MUL_PULSE = 4'd8,
        OP_MUL_NINTH = 4'd9,
        OP_EMIT      = 4'd10
    } t_op;

    typedef enum logic [2:0] {
        COND_NEVER    = 3'd0,
        COND_ALWAYS   = 3'd1,
        COND_NO_INPUT = 3'd2,
        COND_SAT      = 3'd3,
        COND_OUT_BUSY = 3'd4
    } t_cond;

    typedef struct packed {
        t_op   op;
        t_cond cond;
        t_step target;
    } t_uword;

    localparam t_step STEP_IDLE  = 4'd0;
    localparam t_step STEP_PULSE = 4'd7;
    localparam t_step STEP_EMIT  = 4'd9;
    localparam t_step STEP_LAST  = 4'd9;

    function automatic t_uword ucode_rom(input t_step step);
        t_uword w;
        unique case (step)
            4'd0:    w = '{OP_LOAD,      COND_NO_INPUT, STEP_IDLE};
            4'd1:    w = '{OP_MUL_SPEED, COND_NEVER,    STEP_IDLE};
            4'd2:    w = '{OP_MUL_DIST,  COND_NEVER,    STEP_IDLE};
            4'd3:    w = '{OP_CMP,       COND_SAT,      STEP_PULSE};
            4'd4:    w = '{OP_MUL_RECIP, COND_NEVER,    STEP_IDLE};
            4'd5:    w = '{OP_MUL_QBACK, COND_NEVER,    STEP_IDLE};
            4'd6:    w = '{OP_UPDATE,    COND_NEVER,    STEP_IDLE};
            4'd7:    w = '{OP_MUL_PULSE, COND_NEVER,    STEP_IDLE};
            4'd8:    w = '{OP_MUL_NINTH, COND_NEVER,    STEP_IDLE};
            4'd9:    w = '{OP_EMIT,      COND_OUT_BUSY, STEP_EMIT};
            default: w = '{OP_NOP,       COND_ALWAYS,   STEP_IDLE};
        endcase
        return w;
    endfunction

endpackage

// ----- hdl/servo_slew_pulse_generator_core.sv -----
// servo_slew_pulse_generator_core: one-channel servo slew limiter with pulse width output
`timescale 1ns / 1ps

// One servo channel. Each request carries a target angle in whole degrees and a
// free-running millisecond time. The target is clamped (to max_angle when above
// it, else raised to min_angle), and the current angle, held in 2^-ANGLE_FRAC_BITS
// degree units, moves toward it by floor(speed * elapsed_ms * 2^F / 1000) without
// overshoot. Each request yields one result: the new angle, the pulse high time
// 500 + angle * 2000 / 180 us (mirrored when reverse is set, 0 above 180 degrees)
// and an arrived flag. A short microcode program steps a single 32x32 multiplier
// and its product register through the work: a request runs every step when the
// slew step does not saturate and skips the divide and update steps when it does,
// and its result may wait on a stalled output register. A new request is taken
// only while the program sits at its idle step, which it reaches once the previous
// result is loaded into the output register, so the output may still hold an
// untaken result. Configuration writes are applied at once and are expected only
// while no request is in flight.

module servo_slew_pulse_generator_core #(
    parameter int ANGLE_FRAC_BITS = ssp_pkg::ANGLE_FRAC_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration write port
    input  logic                            i_cfg_wr_en,
    input  logic [ssp_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [ssp_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    // request stream
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [ssp_pkg::S_TDATA_W-1:0]   s_axis_tdata,  // [7:0] target_angle, [39:8] now_ms
    // result stream
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [ssp_pkg::M_TDATA_W-1:0]   m_axis_tdata   // [13:0] angle_now, [25:14] pulse_us,
                                                           // [26] arrived, [31:27] zero
);
    import ssp_pkg::*;

    // angle width in fixed point
    localparam int AW = 8 + ANGLE_FRAC_BITS;
    // width of speed * elapsed * 2^F
    localparam int PW = 42 + ANGLE_FRAC_BITS;
    localparam logic [AW-1:0] ANG_180 = AW'(180) << ANGLE_FRAC_BITS;

    // configuration registers
    logic [7:0] r_min_angle;
    logic [7:0] r_max_angle;
    logic [9:0] r_speed;
    logic       r_reverse;

    // channel state
    logic [AW-1:0] r_cur;
    logic [31:0]   r_last;

    // datapath registers
    t_step         r_step, n_step;
    logic [AW-1:0] r_tgt;
    logic [31:0]   r_elapsed;
    logic [PW-1:0] r_p;
    logic [63:0]   r_m;
    logic [AW-1:0] r_q;

    // output register
    logic                 r_out_valid;
    logic [M_TDATA_W-1:0] r_out_data;

    t_uword        uw;
    logic          accept;
    logic          sat;
    logic          up;
    logic          jump;
    logic [AW-1:0] span;
    logic [AW-1:0] mirror;
    logic [7:0]    tgt_in;
    logic [7:0]    tgt_clamp;
    logic [31:0]   now_in;
    logic [31:0]   mul_a, mul_b;
    logic [30:0]   rem;
    logic [AW-1:0] q_fix;
    logic [14:0]   pulse_div;
    logic [10:0]   pulse_q;
    logic [11:0]   pulse;

    // current control word
    assign uw = ucode_rom(r_step);

    assign s_axis_tready = (uw.op == OP_LOAD);
    assign accept = s_axis_tvalid && s_axis_tready;

    assign tgt_in = s_axis_tdata[7:0];
    assign now_in = s_axis_tdata[39:8];

    // max is tested first, so min wins only below an in-range target
    always_comb begin
        priority if (tgt_in > r_max_angle) begin
            tgt_clamp = r_max_angle;
        end else if (tgt_in < r_min_angle) begin
            tgt_clamp = r_min_angle;
        end else begin
            tgt_clamp = tgt_in;
        end
    end

    // remaining distance and direction
    assign up   = (r_tgt > r_cur);
    assign span = up ? (r_tgt - r_cur) : (r_cur - r_tgt);

    // step reaches the target when speed*elapsed*2^F >= 1000*span
    assign sat = (64'(r_p) >= r_m);

    // quotient estimate may be one low, the remainder fixes it
    assign rem   = r_p[30:0] - r_m[30:0];
    assign q_fix = r_q + AW'(rem >= 31'(K_THOUSAND));

    assign mirror = r_reverse ? (ANG_180 - r_cur) : r_cur;

    // a*2000/(180*2^F) == floor((a*100 >> F) / 9)
    assign pulse_div = 15'(r_m >> ANGLE_FRAC_BITS);
    assign pulse_q   = r_m[RECIP_9_SH +: 11];
    assign pulse     = (r_cur > ANG_180) ? 12'd0 : (12'(pulse_q) + K_PULSE_BASE);

    // shared multiplier operand select
    always_comb begin
        unique case (uw.op)
            OP_MUL_SPEED: begin
                mul_a = 32'(r_speed);
                mul_b = r_elapsed;
            end
            OP_MUL_DIST: begin
                mul_a = 32'(span);
                mul_b = K_THOUSAND;
            end
            OP_MUL_RECIP: begin
                mul_a = 32'(r_p[29:0]);
                mul_b = RECIP_1000;
            end
            OP_MUL_QBACK: begin
                mul_a = 32'(r_m[RECIP_1000_SH +: AW]);
                mul_b = K_THOUSAND;
            end
            OP_MUL_PULSE: begin
                mul_a = 32'(mirror);
                mul_b = K_HUNDRED;
            end
            OP_MUL_NINTH: begin
                mul_a = 32'(pulse_div);
                mul_b = RECIP_9;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // sequencer branch conditions
    always_comb begin
        unique case (uw.cond)
            COND_NEVER:    jump = 1'b0;
            COND_ALWAYS:   jump = 1'b1;
            COND_NO_INPUT: jump = !s_axis_tvalid;
            COND_SAT:      jump = sat;
            COND_OUT_BUSY: jump = r_out_valid && !m_axis_tready;
            default:       jump = 1'b0;
        endcase
    end

    always_comb begin
        priority if (jump) begin
            n_step = uw.target;
        end else if (r_step == STEP_LAST) begin
            n_step = STEP_IDLE;
        end else begin
            n_step = r_step + t_step'(1);
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= STEP_IDLE;
            r_min_angle <= 8'd0;
            r_max_angle <= 8'd180;
            r_speed     <= 10'd30;
            r_reverse   <= 1'b0;
            r_cur       <= '0;
            r_last      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_step <= n_step;

            if (i_cfg_wr_en) begin
                unique case (t_reg_idx'(i_cfg_idx))
                    REG_MIN_ANGLE: r_min_angle <= i_cfg_wdata[7:0];
                    REG_MAX_ANGLE: r_max_angle <= i_cfg_wdata[7:0];
                    REG_SPEED:     r_speed     <= i_cfg_wdata;
                    REG_REVERSE:   r_reverse   <= i_cfg_wdata[0];
                    default: ;
                endcase
            end

            if (accept) begin
                r_last <= now_in;
            end

            // saturated step lands exactly on the target
            if (uw.op == OP_CMP && sat) begin
                r_cur <= r_tgt;
            end else if (uw.op == OP_UPDATE) begin
                r_cur <= up ? (r_cur + q_fix) : (r_cur - q_fix);
            end

            if (uw.op == OP_EMIT && !jump) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_tgt     <= AW'(tgt_clamp) << ANGLE_FRAC_BITS;
            r_elapsed <= now_in - r_last;
        end
        if (uw.op == OP_MUL_SPEED || uw.op == OP_MUL_DIST || uw.op == OP_MUL_RECIP ||
            uw.op == OP_MUL_QBACK || uw.op == OP_MUL_PULSE || uw.op == OP_MUL_NINTH) begin
            r_m <= 64'(mul_a) * 64'(mul_b);
        end
        if (uw.op == OP_MUL_DIST) begin
            r_p <= PW'(r_m[41:0]) << ANGLE_FRAC_BITS;
        end
        if (uw.op == OP_MUL_QBACK) begin
            r_q <= r_m[RECIP_1000_SH +: AW];
        end
        if (uw.op == OP_EMIT && !jump) begin
            r_out_data <= {5'd0, (r_cur == r_tgt), pulse, ANGLE_OUT_W'(r_cur)};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

// ----- hdl/ssp_checker.sv -----
// ssp_checker: port-level assertions for the servo slew pulse generator, with bind
`timescale 1ns / 1ps

module ssp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata
);

    // a stalled result holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // pulse is off or inside the servo window
    a_pulse_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[25:14] == 12'd0) ||
                          (m_axis_tdata[25:14] >= 12'd500 && m_axis_tdata[25:14] <= 12'd2500))
        else $error("pulse width out of range");

    // no result appears right after a request is taken
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> !$past(s_axis_tvalid && s_axis_tready))
        else $error("result too soon after request");

    // request side is closed while an item is in flight
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request taken while busy");

    // reset leaves the output empty
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

endmodule

bind servo_slew_pulse_generator_core ssp_checker u_ssp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ----- tb/servo_slew_pulse_generator_core_tb.sv -----
// servo_slew_pulse_generator_core_tb: self-checking stream testbench for the servo slew core
`timescale 1ns / 1ps

module servo_slew_pulse_generator_core_tb;

    import ssp_pkg::*;

    // angle fixed point as built into the core by default
    localparam int          FRAC      = ANGLE_FRAC_BITS_DEF;
    localparam logic [63:0] ANG_ONE   = 64'd1 << FRAC;
    localparam logic [63:0] ANG_180   = 64'd180 << FRAC;
    // generous cycle budget: long gaps, long stalls and the core's own cycles
    // on every request still finish well inside it
    localparam int          CYCLE_LIMIT = 1_000_000;
    // quiet cycles after the last result
    localparam int          SETTLE_CYCLES = 16;
    localparam int          PRINT_CAP = 200;

    typedef struct {
        logic [ANGLE_OUT_W-1:0] angle;
        logic [PULSE_W-1:0]     pulse;
        logic                   arrived;
    } t_servo_result;

    // clock, reset and ports; every input starts at a known value
    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [S_TDATA_W-1:0]  s_axis_tdata = '0;    // [7:0] target_angle, [39:8] now_ms
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_axis_tdata;         // [13:0] angle_now, [25:14] pulse_us,
                                                 // [26] arrived, [31:27] zero

    servo_slew_pulse_generator_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // shadow of the configuration registers
    logic [7:0] lim_lo_deg = 8'd0;
    logic [7:0] lim_hi_deg = 8'd180;
    logic [9:0] slew_rate  = 10'd30;
    logic       mirror     = 1'b0;

    // predicted servo state
    logic [63:0] angle_fx = '0;
    logic [31:0] last_ms  = '0;

    logic [S_TDATA_W-1:0] pending_req_q[$];   // requests not yet offered
    t_servo_result        angle_pulse_q[$];   // predicted results, oldest first

    int  mismatches = 0;
    int  cycle_cnt = 0;
    int  gap_left = 0;
    int  stall_left = 0;
    bit  no_idle = 1'b0;       // phases with back-to-back traffic on both sides
    bit  req_taken = 1'b0;     // request handshake seen at the last rising edge
    logic [31:0] stim_ms = '0; // millisecond clock of the stimulus

    task automatic report(input string what, input int unsigned want, input int unsigned got);
        if (mismatches < PRINT_CAP)
            $display("[%0t] mismatch %s: expected %0d got %0d", $realtime, what, want, got);
        mismatches++;
    endtask

    // one slew update: clamp the target, move toward it without overshoot,
    // then derive the pulse width; updates the predicted state
    function automatic t_servo_result slew_advance(input logic [7:0] tgt_deg,
                                                   input logic [31:0] now);
        logic [7:0]    tgt;
        logic [63:0]   tgt_fx;
        logic [31:0]   dt;
        logic [63:0]   move;
        logic [63:0]   a;
        t_servo_result r;
        // max first, so min above max wins only for low targets
        tgt = tgt_deg;
        if (tgt > lim_hi_deg)
            tgt = lim_hi_deg;
        else if (tgt < lim_lo_deg)
            tgt = lim_lo_deg;
        tgt_fx = 64'(tgt) * ANG_ONE;
        if (tgt_fx != angle_fx) begin
            dt = now - last_ms;   // wraps mod 2^32
            move = (64'(slew_rate) * 64'(dt) * ANG_ONE) / 64'd1000;
            if (tgt_fx > angle_fx) begin
                if (move >= tgt_fx - angle_fx)
                    angle_fx = tgt_fx;
                else
                    angle_fx = angle_fx + move;
            end else begin
                if (move >= angle_fx - tgt_fx)
                    angle_fx = tgt_fx;
                else
                    angle_fx = angle_fx - move;
            end
        end
        last_ms = now;
        r.angle = angle_fx[ANGLE_OUT_W-1:0];
        if (angle_fx > ANG_180) begin
            r.pulse = '0;
        end else begin
            a = mirror ? (ANG_180 - angle_fx) : angle_fx;
            r.pulse = PULSE_W'(64'd500 + (a * 64'd2000) / ANG_180);
        end
        r.arrived = (angle_fx == tgt_fx);
        return r;
    endfunction

    // idle length after a request: mostly none, some short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 60)
            return 0;
        else if (r < 95)
            return $urandom_range(1, 4);
        else
            return $urandom_range(15, 60);
    endfunction

    // receiver stall drawn on each ready cycle, so kept rarer
    function automatic int pick_stall();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 75)
            return 0;
        else if (r < 97)
            return $urandom_range(1, 3);
        else
            return $urandom_range(20, 60);
    endfunction

    // request driver: new data only once the previous request was taken
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            gap_left <= 0;
        end else if (!s_axis_tvalid || req_taken) begin
            if (gap_left != 0) begin
                s_axis_tvalid <= 1'b0;
                gap_left <= gap_left - 1;
            end else if (pending_req_q.size() != 0) begin
                s_axis_tdata <= pending_req_q.pop_front();
                s_axis_tvalid <= 1'b1;
                gap_left <= pick_gap();
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // result side back-pressure
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            stall_left <= 0;
        end else if (stall_left != 0) begin
            m_axis_tready <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            m_axis_tready <= 1'b1;
            stall_left <= pick_stall();
        end
    end

    // monitor: check results against the oldest prediction, predict on each request
    always @(posedge i_clk) begin
        t_servo_result got;
        t_servo_result want;
        if (!i_rst_n) begin
            req_taken <= 1'b0;
        end else begin
            req_taken <= s_axis_tvalid && s_axis_tready;
            if (m_axis_tvalid && m_axis_tready) begin
                got.angle   = m_axis_tdata[ANGLE_OUT_W-1:0];
                got.pulse   = m_axis_tdata[ANGLE_OUT_W +: PULSE_W];
                got.arrived = m_axis_tdata[ANGLE_OUT_W + PULSE_W];
                if (angle_pulse_q.size() == 0) begin
                    report("result with none pending (angle_now)", 0, got.angle);
                end else begin
                    want = angle_pulse_q.pop_front();
                    if (got.angle !== want.angle)
                        report("angle_now", want.angle, got.angle);
                    if (got.pulse !== want.pulse)
                        report("pulse_us", want.pulse, got.pulse);
                    if (got.arrived !== want.arrived)
                        report("arrived", want.arrived, got.arrived);
                end
            end
            // the result of this request cannot be out yet, so predict after checking
            if (s_axis_tvalid && s_axis_tready)
                angle_pulse_q.push_back(slew_advance(s_axis_tdata[7:0], s_axis_tdata[39:8]));
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic write_reg(input t_reg_idx idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_wdata <= val;
        case (idx)
            REG_MIN_ANGLE: lim_lo_deg = val[7:0];
            REG_MAX_ANGLE: lim_hi_deg = val[7:0];
            REG_SPEED:     slew_rate  = val[9:0];
            REG_REVERSE:   mirror     = val[0];
            default: ;
        endcase
    endtask

    // full register set, written only while the core is idle
    task automatic program_limits(input logic [7:0] lo, input logic [7:0] hi,
                                  input logic [9:0] rate, input logic rev);
        write_reg(REG_MIN_ANGLE, CFG_DATA_W'(lo));
        write_reg(REG_MAX_ANGLE, CFG_DATA_W'(hi));
        write_reg(REG_SPEED, rate);
        write_reg(REG_REVERSE, CFG_DATA_W'(rev));
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    // sender pause: hold off until every request went out and every result came back
    task automatic drain_results();
        while (pending_req_q.size() != 0 || s_axis_tvalid || angle_pulse_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic void queue_req(input logic [7:0] tgt, input logic [31:0] now);
        pending_req_q.push_back({now, tgt});
        stim_ms = now;
    endfunction

    // next time stamp: mostly one pwm period or so, sometimes long, rarely anywhere
    function automatic logic [31:0] next_ms();
        int r;
        r = $urandom_range(0, 99);
        if (r < 85)
            return stim_ms + $urandom_range(0, 60);
        else if (r < 97)
            return stim_ms + $urandom_range(0, 5000);
        else
            return $urandom;
    endfunction

    // mostly a held target over a run of periods so the angle gets there,
    // with some isolated noise requests mixed in
    task automatic random_phase(input int n_req);
        int         made;
        int         run_len;
        logic [7:0] goal;
        made = 0;
        while (made < n_req) begin
            if ($urandom_range(0, 9) == 0) begin
                queue_req(8'($urandom), $urandom);
                made++;
            end else begin
                goal = 8'($urandom);
                run_len = $urandom_range(1, 40);
                if (run_len > n_req - made)
                    run_len = n_req - made;
                repeat (run_len) begin
                    queue_req(goal, next_ms());
                    made++;
                end
            end
        end
    endtask

    initial begin
        logic [7:0] lo;
        logic [7:0] hi;
        logic [9:0] rate;

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: equal target at time zero, clamp to max, zero elapsed,
        // saturation, huge elapsed and a wrapping time stamp
        queue_req(8'd0, 32'd0);
        queue_req(8'd255, 32'd1000);
        queue_req(8'd180, 32'd1000);
        queue_req(8'd180, 32'd8000);
        queue_req(8'd0, 32'd8100);
        queue_req(8'd90, 32'hFFFF_FFF0);
        queue_req(8'd0, 32'h0000_0010);
        drain_results();

        // min above max, fastest slew, mirrored: angle goes above 180
        program_limits(8'd200, 8'd50, 10'd1023, 1'b1);
        queue_req(8'd0, 32'h0000_0020);
        queue_req(8'd0, 32'h0000_2000);
        queue_req(8'd255, 32'h0000_2000);
        queue_req(8'd100, 32'h0000_2400);
        queue_req(8'd50, 32'h0000_2800);
        drain_results();

        // zero speed: the angle stays put
        program_limits(8'd0, 8'd255, 10'd0, 1'b0);
        queue_req(8'd255, 32'h0001_0000);
        queue_req(8'd0, 32'h0002_0000);
        drain_results();

        // both limits at the top: largest angle, all-ones and alternating bits
        program_limits(8'd255, 8'd255, 10'd1023, 1'b1);
        queue_req(8'd0, 32'h0003_0000);
        queue_req(8'd128, 32'hFFFF_FFFF);
        queue_req(8'hAA, 32'h5555_5555);
        queue_req(8'h55, 32'hAAAA_AAAA);
        drain_results();

        // mirrored pulse over the whole legal range
        program_limits(8'd0, 8'd180, 10'd1023, 1'b1);
        queue_req(8'd0, stim_ms + 32'd20000);
        queue_req(8'd90, stim_ms + 32'd50);
        queue_req(8'd180, stim_ms + 32'd100000);
        drain_results();

        // random settings per phase; every other phase runs without idling
        for (int ph = 0; ph < 8; ph++) begin
            lo = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 30));
            hi = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(150, 255));
            rate = ($urandom_range(0, 1) == 0) ? 10'($urandom) : 10'($urandom_range(0, 60));
            program_limits(lo, hi, rate, 1'($urandom));
            no_idle = (ph % 2 == 1);
            random_phase(135);
            drain_results();
        end

        if (mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
